/* rtl/aofl_pkg.sv */
// ============================================================================
// aofl_pkg
// Shared constants and codes for the address-ordered free list allocator.
// ============================================================================
`default_nettype none

package aofl_pkg;

   // Default sizing of the heap and of one heap extension, in bytes.
   localparam int HEAP_BYTES_DEF = 65536;
   localparam int GROW_CHUNK_DEF = 4096;

   // Block layout constants, in bytes.
   localparam logic [31:0] MIN_BLOCK     = 32'd24;
   localparam logic [31:0] FIRST_PAYLOAD = 32'd32;
   localparam logic [31:0] LIST_HEAD     = 32'd8;
   localparam logic [31:0] PROLOGUE_HDR  = 32'd25;
   localparam logic [31:0] SENTINEL_HDR  = 32'd1;
   localparam logic [31:0] SUCC_OFFSET   = 32'd8;
   localparam logic [31:0] HDR_OFFSET    = 32'd4;
   localparam logic [31:0] FTR_OFFSET    = 32'd8;
   localparam logic [31:0] ALLOC_BIT     = 32'd1;

   // Request function codes.
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_ZERO   = 2'd1,
      STATUS_NOHEAP = 2'd2
   } status_type;

endpackage

`default_nettype wire

/* rtl/address_ordered_free_list_allocator.sv */
// ============================================================================
// address_ordered_free_list_allocator
// First-fit heap allocator with an address-ordered explicit free list.
// ============================================================================
// A request word (req_func, req_size, req_block_addr) is taken when start is
// high and busy is low. Allocate returns the payload offset of a block of at
// least req_size bytes; release returns the block at req_block_addr to the
// free list and merges it with free neighbors. Each request gives exactly one
// result word on rsp_payload_addr / rsp_status, shown for one cycle with
// rsp_strobe high; the receiver cannot hold it off.
// All heap state (headers, footers, list links) lives in one synchronous
// single-read, single-write memory of HEAP_BYTES/4 words with a registered
// read port; a sequencer performs each access of the algorithm in turn.
// A zero-size allocate shows its result in the next cycle. A fitting allocate
// walks the free list node by node, with more steps when the block is split
// or the heap must grow; a release walks the list to its insertion point and
// then merges by case; a malformed release answers without a walk.
// After reset the block sweeps the whole heap memory, one word per cycle,
// to lay down the initial heap; busy stays high then.
// ============================================================================
`default_nettype none

module address_ordered_free_list_allocator
   import aofl_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF,
   parameter int GROW_CHUNK = GROW_CHUNK_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [16:0] req_size,
   input  wire logic [15:0] req_block_addr,
   output logic             rsp_strobe,
   output logic [15:0]      rsp_payload_addr,
   output logic [1:0]       rsp_status
);

   localparam int MEM_WORDS  = HEAP_BYTES / 4;
   localparam int IW         = $clog2(MEM_WORDS);
   localparam int WALK_LIMIT = HEAP_BYTES / 8 + 4;
   localparam int CW         = $clog2(WALK_LIMIT + 1);
   localparam int G_WORDS    = GROW_CHUNK / 4;
   localparam int INIT_GSZ   = (G_WORDS + G_WORDS % 2) * 4;
   localparam bit INIT_OK    = (40 + INIT_GSZ + 8) <= HEAP_BYTES;
   localparam int INIT_TAIL  = INIT_OK ? 32 + INIT_GSZ : 32;
   localparam int INIT_BRK   = INIT_OK ? 40 + INIT_GSZ : 40;

   localparam logic [31:0] HEAP_LIM  = 32'(HEAP_BYTES);
   localparam logic [31:0] GROW_W    = 32'(GROW_CHUNK);
   localparam logic [31:0] GSZ_W     = 32'(INIT_GSZ);
   localparam logic [31:0] TAIL_W    = 32'(INIT_TAIL);
   localparam logic [31:0] BRK_W     = 32'(INIT_BRK);
   localparam logic [CW-1:0] WALK_W  = CW'(WALK_LIMIT);
   localparam logic [IW-1:0] LAST_IX = IW'(MEM_WORDS - 1);

   typedef enum logic [5:0] {
      ST_INIT, ST_IDLE,
      A_HEAD, A_P, A_CHK, A_SZ, A_NX, G_CALC,
      G_W1, G_W2, G_W3, G_W4, G_W5, G_W6,
      M_0, M_1, M_2, M_3, M_4, M_5,
      MG_1, MG_2, MG_3, MG_4, MG_5, MG_6, M_RET,
      T_RD, T_1,
      S_1, S_2, S_3, S_4, S_5, S_6, S_7, S_8, S_9, S_10, S_11, S_12,
      N_1, N_2, N_3, N_4, N_5, N_6, N_7, N_8,
      R_0, R_1, R_2, R_3, R_4, R_5, R_6,
      I_1, I_2, I_3, I_4, I_5, I_6, I_7, I_8
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] init_ff;
   logic          func_ff;
   logic [31:0]   asize_ff, bp_ff, p_ff, size_ff, hdr_ff, pf_ff;
   logic [31:0]   nxt_ff, prv_ff, t_ff, l_ff, rest_ff, tmp_ff;
   logic [31:0]   tail_ff, brk_ff;
   logic [CW-1:0] n_ff;
   logic          rsp_strobe_ff;
   logic [15:0]   rsp_addr_ff;
   status_type    rsp_status_ff;

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_q_ff;
   logic        rd_zero_ff;
   logic [31:0] rd_data, rd_addr, wr_addr, wr_data;
   logic        wr_en, rd_ok, wr_ok;
   logic [31:0] grow_ext, grow_words, grow_size, req_asize, bp_in, rd_size;

   // Word value of the initial heap at byte address a.
   function automatic logic [31:0] init_word(input logic [31:0] a);
      logic [31:0] v;
      v = '0;
      if (a == HDR_OFFSET) v = PROLOGUE_HDR;
      if (a == LIST_HEAD + SUCC_OFFSET) v = FIRST_PAYLOAD;
      if (a == 32'd24) v = PROLOGUE_HDR;
      if (a == 32'd28) v = INIT_OK ? GSZ_W : SENTINEL_HDR;
      if (a == FIRST_PAYLOAD) v = LIST_HEAD;
      if (a == 32'd40) v = INIT_OK ? TAIL_W : 32'd0;
      if (INIT_OK) begin
         if (a == FIRST_PAYLOAD + GSZ_W - FTR_OFFSET) v = GSZ_W;
         if (a == TAIL_W - HDR_OFFSET) v = SENTINEL_HDR;
         if (a == TAIL_W) v = FIRST_PAYLOAD;
         if (a == TAIL_W + SUCC_OFFSET) v = 32'd0;
      end
      return v;
   endfunction

   assign rd_data = rd_zero_ff ? 32'd0 : mem_q_ff;
   assign rd_size = {rd_data[31:3], 3'b000};
   assign rd_ok   = rd_addr < HEAP_LIM;
   assign wr_ok   = wr_addr < HEAP_LIM;

   // Heap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_addr[IW+1:2]] <= wr_data;
      end
      mem_q_ff   <= mem[rd_addr[IW+1:2]];
      rd_zero_ff <= !rd_ok;
   end

   assign req_asize  = (req_size <= 17'd16) ? MIN_BLOCK
                     : ((32'(req_size) + 32'd15) & ~32'd7);
   assign grow_ext   = (asize_ff > GROW_W) ? asize_ff : GROW_W;
   assign grow_words = (grow_ext >> 2) + {31'd0, grow_ext[2]};
   assign grow_size  = grow_words << 2;
   assign bp_in      = {16'd0, req_block_addr};

   // Memory access of each sequencer step.
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = 32'({init_ff, 2'b00});
            wr_data = init_word(32'({init_ff, 2'b00}));
         end
         A_HEAD: rd_addr = LIST_HEAD + SUCC_OFFSET;
         A_CHK:  rd_addr = p_ff - HDR_OFFSET;
         A_SZ:   rd_addr = p_ff + SUCC_OFFSET;
         G_W1: begin
            wr_en = 1'b1; wr_addr = bp_ff - HDR_OFFSET; wr_data = size_ff;
         end
         G_W2: begin
            wr_en = 1'b1; wr_addr = bp_ff + size_ff - FTR_OFFSET; wr_data = size_ff;
         end
         G_W3: begin
            wr_en = 1'b1; wr_addr = bp_ff + SUCC_OFFSET; wr_data = tail_ff;
         end
         G_W4: begin
            wr_en = 1'b1; wr_addr = tail_ff - HDR_OFFSET; wr_data = SENTINEL_HDR;
         end
         G_W5: begin
            wr_en = 1'b1; wr_addr = tail_ff; wr_data = bp_ff;
         end
         G_W6: begin
            wr_en = 1'b1; wr_addr = tail_ff + SUCC_OFFSET; wr_data = 32'd0;
         end
         M_0: rd_addr = bp_ff - FTR_OFFSET;
         M_1: rd_addr = bp_ff - HDR_OFFSET;
         M_3: rd_addr = bp_ff + size_ff - HDR_OFFSET;
         M_4: rd_addr = prv_ff - HDR_OFFSET;
         MG_1, MG_3: rd_addr = l_ff + SUCC_OFFSET;
         MG_2: begin
            wr_en = 1'b1; wr_addr = t_ff + SUCC_OFFSET; wr_data = rd_data;
         end
         MG_4: begin
            wr_en = 1'b1; wr_addr = rd_data; wr_data = t_ff;
         end
         MG_5: begin
            wr_en = 1'b1; wr_addr = t_ff - HDR_OFFSET; wr_data = size_ff;
         end
         MG_6: begin
            wr_en = 1'b1; wr_addr = t_ff + size_ff - FTR_OFFSET; wr_data = size_ff;
         end
         T_RD: rd_addr = bp_ff - HDR_OFFSET;
         S_1: begin
            wr_en = 1'b1; wr_addr = bp_ff - HDR_OFFSET; wr_data = asize_ff | ALLOC_BIT;
         end
         S_2: begin
            wr_en   = 1'b1;
            wr_addr = bp_ff + asize_ff - FTR_OFFSET;
            wr_data = asize_ff | ALLOC_BIT;
         end
         S_3: rd_addr = bp_ff + SUCC_OFFSET;
         S_4: begin
            wr_en = 1'b1; wr_addr = rest_ff + SUCC_OFFSET; wr_data = rd_data;
         end
         S_5: rd_addr = bp_ff;
         S_6: begin
            wr_en = 1'b1; wr_addr = rest_ff; wr_data = rd_data;
         end
         S_7: rd_addr = rest_ff;
         S_8: begin
            wr_en = 1'b1; wr_addr = rd_data + SUCC_OFFSET; wr_data = rest_ff;
         end
         S_9: rd_addr = rest_ff + SUCC_OFFSET;
         S_10: begin
            wr_en = 1'b1; wr_addr = rd_data; wr_data = rest_ff;
         end
         S_11: begin
            wr_en = 1'b1; wr_addr = rest_ff - HDR_OFFSET; wr_data = size_ff - asize_ff;
         end
         S_12: begin
            wr_en   = 1'b1;
            wr_addr = rest_ff + (size_ff - asize_ff) - FTR_OFFSET;
            wr_data = size_ff - asize_ff;
         end
         N_1: begin
            wr_en = 1'b1; wr_addr = bp_ff - HDR_OFFSET; wr_data = size_ff | ALLOC_BIT;
         end
         N_2: begin
            wr_en   = 1'b1;
            wr_addr = bp_ff + size_ff - FTR_OFFSET;
            wr_data = size_ff | ALLOC_BIT;
         end
         N_3, N_6: rd_addr = bp_ff;
         N_4, N_7: rd_addr = bp_ff + SUCC_OFFSET;
         N_5: begin
            wr_en = 1'b1; wr_addr = tmp_ff + SUCC_OFFSET; wr_data = rd_data;
         end
         // The successor's pred link takes the block's predecessor.
         N_8: begin
            wr_en = 1'b1; wr_addr = rd_data; wr_data = tmp_ff;
         end
         R_0: rd_addr = bp_ff - HDR_OFFSET;
         R_2: rd_addr = bp_ff + size_ff - FTR_OFFSET;
         R_3: rd_addr = LIST_HEAD + SUCC_OFFSET;
         R_5: rd_addr = p_ff + SUCC_OFFSET;
         I_1: begin
            wr_en = 1'b1; wr_addr = bp_ff - HDR_OFFSET; wr_data = size_ff;
         end
         I_2: begin
            wr_en = 1'b1; wr_addr = bp_ff + size_ff - FTR_OFFSET; wr_data = size_ff;
         end
         I_3: begin
            wr_en = 1'b1; wr_addr = bp_ff + SUCC_OFFSET; wr_data = p_ff;
         end
         I_4, I_6: rd_addr = p_ff;
         I_5: begin
            wr_en = 1'b1; wr_addr = bp_ff; wr_data = rd_data;
         end
         I_7: begin
            wr_en = 1'b1; wr_addr = rd_data + SUCC_OFFSET; wr_data = bp_ff;
         end
         I_8: begin
            wr_en = 1'b1; wr_addr = p_ff; wr_data = bp_ff;
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_ff       <= '0;
         tail_ff       <= TAIL_W;
         brk_ff        <= BRK_W;
         n_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == LAST_IX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  asize_ff <= req_asize;
                  bp_ff    <= bp_in;
                  if (req_func == FUNC_RELEASE) begin
                     state_ff <= R_0;
                  end else if (req_size == 17'd0) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_addr_ff   <= '0;
                     rsp_status_ff <= STATUS_ZERO;
                  end else begin
                     state_ff <= A_HEAD;
                  end
               end
            end
            A_HEAD: state_ff <= A_P;
            A_P: begin
               p_ff     <= rd_data;
               n_ff     <= '0;
               state_ff <= A_CHK;
            end
            A_CHK: begin
               if (n_ff < WALK_W && p_ff != tail_ff) begin
                  state_ff <= A_SZ;
               end else begin
                  state_ff <= G_CALC;
               end
            end
            A_SZ: begin
               if (asize_ff <= rd_size) begin
                  bp_ff    <= p_ff;
                  state_ff <= T_RD;
               end else begin
                  state_ff <= A_NX;
               end
            end
            A_NX: begin
               p_ff     <= rd_data;
               n_ff     <= n_ff + 1'b1;
               state_ff <= A_CHK;
            end
            G_CALC: begin
               if (brk_ff + grow_size + 32'd8 > HEAP_LIM) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_NOHEAP;
                  state_ff      <= ST_IDLE;
               end else begin
                  bp_ff    <= tail_ff;
                  size_ff  <= grow_size;
                  state_ff <= G_W1;
               end
            end
            G_W1: state_ff <= G_W2;
            G_W2: begin
               tail_ff  <= bp_ff + size_ff;
               state_ff <= G_W3;
            end
            G_W3: state_ff <= G_W4;
            G_W4: state_ff <= G_W5;
            G_W5: state_ff <= G_W6;
            G_W6: begin
               brk_ff   <= brk_ff + size_ff;
               state_ff <= M_0;
            end
            M_0: state_ff <= M_1;
            M_1: begin
               pf_ff    <= rd_data;
               state_ff <= M_2;
            end
            M_2: begin
               size_ff  <= rd_size;
               state_ff <= M_3;
            end
            M_3: begin
               nxt_ff   <= bp_ff + size_ff;
               prv_ff   <= bp_ff - {pf_ff[31:3], 3'b000};
               state_ff <= M_4;
            end
            M_4: begin
               // The four merge cases by the allocated bits of both neighbors.
               priority if (pf_ff[0] && rd_data[0]) begin
                  t_ff     <= bp_ff;
                  state_ff <= M_RET;
               end else if (pf_ff[0]) begin
                  t_ff     <= bp_ff;
                  l_ff     <= nxt_ff;
                  size_ff  <= size_ff + rd_size;
                  state_ff <= MG_1;
               end else if (rd_data[0]) begin
                  t_ff     <= prv_ff;
                  l_ff     <= bp_ff;
                  size_ff  <= size_ff + {pf_ff[31:3], 3'b000};
                  state_ff <= MG_1;
               end else begin
                  t_ff     <= prv_ff;
                  l_ff     <= nxt_ff;
                  size_ff  <= size_ff + rd_size;
                  state_ff <= M_5;
               end
            end
            M_5: begin
               size_ff  <= size_ff + rd_size;
               state_ff <= MG_1;
            end
            MG_1: state_ff <= MG_2;
            MG_2: state_ff <= MG_3;
            MG_3: state_ff <= MG_4;
            MG_4: state_ff <= MG_5;
            MG_5: state_ff <= MG_6;
            MG_6: state_ff <= M_RET;
            M_RET: begin
               if (func_ff == FUNC_RELEASE) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_DONE;
                  state_ff      <= ST_IDLE;
               end else if (t_ff == 32'd0) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_NOHEAP;
                  state_ff      <= ST_IDLE;
               end else begin
                  bp_ff    <= t_ff;
                  state_ff <= T_RD;
               end
            end
            T_RD: state_ff <= T_1;
            T_1: begin
               size_ff <= rd_size;
               rest_ff <= bp_ff + asize_ff;
               if (rd_size >= asize_ff + MIN_BLOCK) begin
                  state_ff <= S_1;
               end else begin
                  state_ff <= N_1;
               end
            end
            S_1:  state_ff <= S_2;
            S_2:  state_ff <= S_3;
            S_3:  state_ff <= S_4;
            S_4:  state_ff <= S_5;
            S_5:  state_ff <= S_6;
            S_6:  state_ff <= S_7;
            S_7:  state_ff <= S_8;
            S_8:  state_ff <= S_9;
            S_9:  state_ff <= S_10;
            S_10: state_ff <= S_11;
            S_11: state_ff <= S_12;
            S_12, N_8: begin
               rsp_strobe_ff <= 1'b1;
               rsp_addr_ff   <= bp_ff[15:0];
               rsp_status_ff <= STATUS_DONE;
               state_ff      <= ST_IDLE;
            end
            N_1: state_ff <= N_2;
            N_2: state_ff <= N_3;
            N_3: state_ff <= N_4;
            N_4: begin
               tmp_ff   <= rd_data;
               state_ff <= N_5;
            end
            N_5: state_ff <= N_6;
            N_6: state_ff <= N_7;
            N_7: begin
               tmp_ff   <= rd_data;
               state_ff <= N_8;
            end
            R_0: state_ff <= R_1;
            R_1: begin
               hdr_ff   <= rd_data;
               size_ff  <= rd_size;
               state_ff <= R_2;
            end
            R_2: begin
               if (bp_ff[2:0] != 3'd0 || bp_ff < FIRST_PAYLOAD || !hdr_ff[0] ||
                   size_ff < MIN_BLOCK || bp_ff + size_ff > tail_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_DONE;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= R_3;
               end
            end
            R_3: begin
               if (rd_data != hdr_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_DONE;
                  state_ff      <= ST_IDLE;
               end else begin
                  state_ff <= R_4;
               end
            end
            R_4: begin
               p_ff     <= rd_data;
               n_ff     <= '0;
               state_ff <= R_5;
            end
            R_5: begin
               priority if (n_ff >= WALK_W) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_addr_ff   <= '0;
                  rsp_status_ff <= STATUS_DONE;
                  state_ff      <= ST_IDLE;
               end else if (bp_ff < p_ff) begin
                  state_ff <= I_1;
               end else begin
                  state_ff <= R_6;
               end
            end
            R_6: begin
               p_ff     <= rd_data;
               n_ff     <= n_ff + 1'b1;
               state_ff <= R_5;
            end
            I_1: state_ff <= I_2;
            I_2: state_ff <= I_3;
            I_3: state_ff <= I_4;
            I_4: state_ff <= I_5;
            I_5: state_ff <= I_6;
            I_6: state_ff <= I_7;
            I_7: state_ff <= I_8;
            I_8: state_ff <= M_0;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_payload_addr = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

/* dv/address_ordered_free_list_allocator_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_ordered_free_list_allocator_chk
// Watches the request and result channels of the allocator. It keeps its own
// copy of the heap, the free list ends and the break, works out the result of
// every accepted request word, and compares each result word with the oldest
// one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module address_ordered_free_list_allocator_chk
   import aofl_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF,
   parameter int GROW_CHUNK = GROW_CHUNK_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_func,
   input  wire logic [16:0] req_size,
   input  wire logic [15:0] req_block_addr,
   input  wire logic        rsp_strobe,
   input  wire logic [15:0] rsp_payload_addr,
   input  wire logic [1:0]  rsp_status,
   output int               fail_count,
   output int               words_due
);

   localparam int HEAP_WORDS = HEAP_BYTES / 4;
   localparam int WALK_MAX   = HEAP_BYTES / 8 + 4;

   typedef struct packed {
      logic [15:0] payload_addr;
      status_type  status;
   } alloc_result_type;

   bit [31:0] heap_image [0:HEAP_WORDS-1];
   bit [31:0] free_head, free_tail, brk;
   alloc_result_type due_results[$];

   assign words_due = due_results.size();

   function automatic bit [31:0] peek(bit [31:0] a);
      bit [31:0] i;
      i = a >> 2;
      return (i < HEAP_WORDS) ? heap_image[i] : 32'd0;
   endfunction

   function automatic void poke(bit [31:0] a, bit [31:0] v);
      bit [31:0] i;
      i = a >> 2;
      if (i < HEAP_WORDS) heap_image[i] = v;
   endfunction

   function automatic bit [31:0] blk_size(bit [31:0] bp);
      return peek(bp - 4) & ~32'd7;
   endfunction

   function automatic bit [31:0] coalesce(bit [31:0] bp);
      bit [31:0] pf, sz, nxt, prv, nh;
      bit prev_used, next_used;
      pf = peek(bp - 8);
      sz = blk_size(bp);
      nxt = bp + sz;
      nh = peek(nxt - 4);
      prev_used = pf[0];
      next_used = nh[0];
      prv = bp - (pf & ~32'd7);
      if (prev_used && next_used) return bp;
      if (prev_used) begin
         sz += blk_size(nxt);
         poke(bp + 8, peek(nxt + 8));
         poke(peek(nxt + 8), bp);
         poke(bp - 4, sz);
         poke(bp + sz - 8, sz);
         return bp;
      end
      if (next_used) begin
         sz += pf & ~32'd7;
         poke(prv + 8, peek(bp + 8));
         poke(peek(bp + 8), prv);
      end else begin
         sz += blk_size(prv) + blk_size(nxt);
         poke(prv + 8, peek(nxt + 8));
         poke(peek(nxt + 8), prv);
      end
      poke(prv - 4, sz);
      poke(prv + sz - 8, sz);
      return prv;
   endfunction

   function automatic bit [31:0] grow_heap(bit [31:0] bytes);
      bit [31:0] words, sz, bp;
      words = bytes / 4;
      if (words[0]) words++;
      sz = words * 4;
      if (brk + sz + 8 > HEAP_BYTES) return 0;
      bp = free_tail;
      poke(bp - 4, sz);
      poke(bp + sz - 8, sz);
      free_tail = bp + sz;
      poke(bp + 8, free_tail);
      poke(free_tail - 4, 1);
      poke(free_tail, bp);
      poke(free_tail + 8, 0);
      brk += sz;
      return coalesce(bp);
   endfunction

   function automatic bit [31:0] first_free_fit(bit [31:0] asize);
      bit [31:0] p;
      p = peek(free_head + 8);
      for (int n = 0; n < WALK_MAX && p != free_tail; n++) begin
         if (asize <= blk_size(p)) return p;
         p = peek(p + 8);
      end
      return 0;
   endfunction

   function automatic void carve(bit [31:0] bp, bit [31:0] asize);
      bit [31:0] sz, rest;
      sz = blk_size(bp);
      if (sz >= asize + MIN_BLOCK) begin
         rest = bp + asize;
         poke(bp - 4, asize | 1);
         poke(bp + asize - 8, asize | 1);
         poke(rest + 8, peek(bp + 8));
         poke(rest, peek(bp));
         poke(peek(rest) + 8, rest);
         poke(peek(rest + 8), rest);
         poke(rest - 4, sz - asize);
         poke(rest + (sz - asize) - 8, sz - asize);
      end else begin
         poke(bp - 4, sz | 1);
         poke(bp + sz - 8, sz | 1);
         poke(peek(bp) + 8, peek(bp + 8));
         poke(peek(bp + 8), peek(bp));
      end
   endfunction

   function automatic void give_back(bit [31:0] bp);
      bit [31:0] hdr, sz, p;
      hdr = peek(bp - 4);
      sz = hdr & ~32'd7;
      if ((bp & 7) != 0 || bp < FIRST_PAYLOAD || hdr[0] == 1'b0 || sz < MIN_BLOCK ||
          bp + sz > free_tail || peek(bp + sz - 8) != hdr)
         return;
      p = peek(free_head + 8);
      for (int n = 0; n < WALK_MAX; n++) begin
         if (bp < p) begin
            poke(bp - 4, sz);
            poke(bp + sz - 8, sz);
            poke(bp + 8, p);
            poke(bp, peek(p));
            poke(peek(p) + 8, bp);
            poke(p, bp);
            void'(coalesce(bp));
            return;
         end
         p = peek(p + 8);
      end
   endfunction

   function automatic void heap_init();
      for (int i = 0; i < HEAP_WORDS; i++) heap_image[i] = 0;
      poke(4, MIN_BLOCK | 1);
      free_head = LIST_HEAD;
      free_tail = FIRST_PAYLOAD;
      poke(free_head, 0);
      poke(free_head + 8, free_tail);
      poke(24, MIN_BLOCK | 1);
      poke(free_tail - 4, 1);
      poke(free_tail, free_head);
      poke(free_tail + 8, 0);
      brk = 40;
      void'(grow_heap(GROW_CHUNK));
   endfunction

   function automatic alloc_result_type serve(logic f, logic [16:0] sz, logic [15:0] addr);
      alloc_result_type r;
      bit [31:0] asize, bp, ext;
      r.payload_addr = '0;
      r.status = STATUS_DONE;
      if (f == FUNC_RELEASE) begin
         give_back({16'd0, addr});
      end else if (sz == 0) begin
         r.status = STATUS_ZERO;
      end else begin
         asize = (sz <= 16) ? MIN_BLOCK : 8 * ((sz + 15) / 8);
         bp = first_free_fit(asize);
         if (bp == 0) begin
            ext = (asize > GROW_CHUNK) ? asize : GROW_CHUNK;
            bp = grow_heap(ext);
         end
         if (bp == 0) begin
            r.status = STATUS_NOHEAP;
         end else begin
            carve(bp, asize);
            r.payload_addr = bp[15:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         fail_count = 0;
         heap_init();
         due_results.delete();
      end else begin
         if (start && !busy) due_results.push_back(serve(req_func, req_size, req_block_addr));
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word addr=%0d status=%0d",
                           $realtime, rsp_payload_addr, rsp_status);
            end else begin
               want = due_results.pop_front();
               if (rsp_payload_addr !== want.payload_addr || rsp_status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: expected addr=%0d status=%0d, got %0d %0d",
                              $realtime, want.payload_addr, want.status,
                              rsp_payload_addr, rsp_status);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* dv/address_ordered_free_list_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_ordered_free_list_allocator_tb
// Drives allocate and release request words into the allocator: a directed
// opening over sizes, coalescing orders and bad releases, then random
// traffic in three pacing phases. A checker beside the block judges results.
// ----------------------------------------------------------------------------
`default_nettype none

module address_ordered_free_list_allocator_tb;
   import aofl_pkg::*;

   localparam int RANDOM_WORDS = 1500;
   localparam longint CYCLE_LIMIT = 50000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = FUNC_ALLOC;
   logic [16:0] req_size = '0;
   logic [15:0] req_block_addr = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_payload_addr;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          words_due;
   int          gap_pct = 0;
   longint      cycle_count = 0;
   logic [15:0] live_blocks[$];
   logic [15:0] freed_blocks[$];

   always #5 clock = ~clock;

   address_ordered_free_list_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_size(req_size), .req_block_addr(req_block_addr),
      .rsp_strobe(rsp_strobe), .rsp_payload_addr(rsp_payload_addr),
      .rsp_status(rsp_status)
   );

   address_ordered_free_list_allocator_chk u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_size(req_size), .req_block_addr(req_block_addr),
      .rsp_strobe(rsp_strobe), .rsp_payload_addr(rsp_payload_addr),
      .rsp_status(rsp_status), .fail_count(fail_count), .words_due(words_due)
   );

   // Blocks handed out are kept so that most releases name a live block.
   always @(posedge clock)
      if (!reset && rsp_strobe && rsp_status == STATUS_DONE && rsp_payload_addr != 0)
         live_blocks.push_back(rsp_payload_addr);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("address_ordered_free_list_allocator_tb NOT OK");
         $finish;
      end
   end

   task automatic send_word(logic f, logic [16:0] sz, logic [15:0] addr);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_size <= sz;
      req_block_addr <= addr;
      do @(posedge clock); while (busy);
   endtask

   task automatic alloc_word(logic [16:0] sz);
      send_word(FUNC_ALLOC, sz, 16'd0);
   endtask

   // Lets the result of the last word come back so its block is known.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (words_due != 0) @(posedge clock);
   endtask

   task automatic free_live(int idx);
      logic [15:0] a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(a);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      send_word(FUNC_RELEASE, 17'd0, a);
   endtask

   task automatic random_word();
      int pick;
      pick = $urandom_range(99);
      if (live_blocks.size() != 0 && (pick < 40 || (live_blocks.size() > 60 && pick < 80))) begin
         free_live($urandom_range(live_blocks.size() - 1));
      end else if (pick < 84) begin
         case ($urandom_range(9))
            0: alloc_word(17'($urandom_range(1, 16)));
            1: alloc_word(17'($urandom_range(4000, 9000)));
            2: alloc_word($urandom_range(0, 131071) < 4 ? 17'd0 : 17'($urandom_range(1, 600)));
            default: alloc_word(17'($urandom_range(1, 200)));
         endcase
      end else if (pick < 88) begin
         alloc_word(17'($urandom_range(0, 131071)));
      end else if (pick < 93 && freed_blocks.size() != 0) begin
         send_word(FUNC_RELEASE, 17'($urandom),
                   freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
      end else begin
         send_word(FUNC_RELEASE, 17'($urandom), 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: size extremes, a full-heap refusal, bad releases.
      alloc_word(17'd0);
      alloc_word(17'd1);
      alloc_word(17'd16);
      alloc_word(17'd17);
      alloc_word(17'd4096);
      alloc_word(17'd4097);
      alloc_word(17'h10000);
      alloc_word(17'h1FFFF);
      send_word(FUNC_RELEASE, 17'h1FFFF, 16'hFFFF);
      send_word(FUNC_RELEASE, 17'd0, 16'd0);
      send_word(FUNC_RELEASE, 17'd0, 16'd36);
      send_word(FUNC_RELEASE, 17'd0, 16'd8);
      settle();
      // Four neighbors freed in orders that hit the no-merge and two-sided merge cases.
      alloc_word(17'd40);
      alloc_word(17'd40);
      alloc_word(17'd40);
      alloc_word(17'd40);
      settle();
      free_live(live_blocks.size() - 4);
      free_live(live_blocks.size() - 2);
      free_live(live_blocks.size() - 2);
      free_live(live_blocks.size() - 1);
      send_word(FUNC_RELEASE, 17'd0, freed_blocks[freed_blocks.size() - 1]);
      free_live(0);
      settle();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) gap_pct = 65;
         else if (i == 2 * RANDOM_WORDS / 3) gap_pct = 0;
         else if (i == 0) gap_pct = 19;
         random_word();
         if (i % 8 == 0) settle();
      end
      settle();
      repeat (200) @(posedge clock);

      if (fail_count == 0 && words_due == 0) begin
         $display("address_ordered_free_list_allocator_tb OK");
      end else begin
         $display("address_ordered_free_list_allocator_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/aofl_pkg.sv
rtl/address_ordered_free_list_allocator.sv
dv/address_ordered_free_list_allocator_chk.sv
dv/address_ordered_free_list_allocator_tb.sv
